// ----- hw/rtl/assert_macros.svh -----
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define SFC_ASSERT_IMPLY(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define SFC_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ----- hw/rtl/sfc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfc_pkg
// types and constants of the stuffed serial frame codec
// ----------------------------------------------------------------------------
package sfc_pkg;

    localparam int BUFFER_BYTES = 256;

    localparam logic [7:0] ESC_BYTE  = 8'h7d;
    localparam logic [7:0] FLAG_BYTE = 8'h7e;
    localparam logic [7:0] ESC_MASK  = 8'h20;
    localparam logic [8:0] LEN_ADD   = 9'd6;
    localparam logic [8:0] LEN_INDEX = 9'd2;

    localparam logic [7:0] START_FLAG_RESET    = 8'h7e;
    localparam logic       STUFFING_RESET      = 1'b1;
    localparam logic [7:0] HEADER_LENGTH_RESET = 8'd4;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        FUNC_RX      = 2'd0,
        FUNC_TX      = 2'd1,
        FUNC_RELEASE = 2'd2,
        FUNC_NOP     = 2'd3
    } func_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_START_FLAG    = 2'd0,
        CFG_STUFFING      = 2'd1,
        CFG_HEADER_LENGTH = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic [7:0] index;
        logic       frame_end;
        logic       overflow;
        logic       last;
    } result_t;

endpackage
`default_nettype wire

// ----- hw/rtl/sfc_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfc_if
// valid/ready channels for codec commands and codec results
// ----------------------------------------------------------------------------
interface sfc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] data_byte;

    modport source (output valid, output func, output data_byte, input ready);
    modport sink   (input valid, input func, input data_byte, output ready);
endinterface

interface sfc_out_if;
    logic       valid;
    logic       ready;
    logic       out_kind;
    logic [7:0] out_byte;
    logic [7:0] out_index;
    logic       frame_end;
    logic       overflow;
    logic       last;

    modport source (output valid, output out_kind, output out_byte, output out_index,
                    output frame_end, output overflow, output last, input ready);
    modport sink   (input valid, input out_kind, input out_byte, input out_index,
                    input frame_end, input overflow, input last, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/sfc_result_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfc_result_fifo
// small result queue, takes up to two items per cycle, gives one
// ----------------------------------------------------------------------------
module sfc_result_fifo (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire  [1:0]                   push_count,
    input  wire  sfc_pkg::result_t       push0,
    input  wire  sfc_pkg::result_t       push1,
    input  wire                          pop,
    output sfc_pkg::result_t             head,
    output logic                         not_empty,
    output logic [sfc_pkg::FIFO_CNT_W-1:0] free_slots
);
    import sfc_pkg::*;

    result_t                 mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   count_reg, count_next;
    logic [FIFO_PTR_W-1:0]   wr_ptr_plus1;
    logic                    do_pop;

    assign wr_ptr_plus1 = FIFO_PTR_W'(wr_ptr_reg + 1'b1);
    assign do_pop       = pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = FIFO_PTR_W'(wr_ptr_reg + FIFO_PTR_W'(push_count));
        rd_ptr_next = do_pop ? FIFO_PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = FIFO_CNT_W'(count_reg + FIFO_CNT_W'(push_count) - FIFO_CNT_W'(do_pop));
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push0;
        end
        if (push_count == 2'd2)
        begin
            mem_reg[wr_ptr_plus1] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head       = mem_reg[rd_ptr_reg];
    assign not_empty  = (count_reg != '0);
    assign free_slots = FIFO_CNT_W'(FIFO_DEPTH) - count_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/stuffed_serial_frame_codec_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stuffed_serial_frame_codec_unit
// receive deframer with unescaping and transmit byte stuffer
// ----------------------------------------------------------------------------
// an accepted item goes to the input register, then its results to the queue
// throughput: one item per cycle while the queue has room for all its results;
//   a stuffed transmit byte gives two results, which leave one at a time
// through the single output; the four-entry result queue decouples input from a stalled output
// reset: asynchronous, clears frame state and queue, loads register defaults
// ----------------------------------------------------------------------------
module stuffed_serial_frame_codec_unit (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_we,
    input  wire [sfc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire [sfc_pkg::CFG_DATA_W-1:0]    cfg_data,
    sfc_in_if.sink                           item_in,
    sfc_out_if.source                        item_out
);
    import sfc_pkg::*;

    // configuration
    logic [7:0] start_flag_reg;
    logic       stuffing_reg;
    logic [7:0] header_length_reg;

    // input register
    logic       s1_valid_reg, s1_valid_next;
    logic [1:0] s1_func_reg;
    logic [7:0] s1_data_reg;

    // frame state
    logic       receiving_reg, receiving_next;
    logic       complete_reg, complete_next;
    logic       escape_reg, escape_next;
    logic [8:0] count_reg, count_next;
    logic [8:0] expected_reg, expected_next;

    logic [7:0] rx_c;
    logic [8:0] exp_v;
    logic [8:0] cnt_inc;
    logic       ovf;
    logic       fend;
    logic [1:0] n_results;
    result_t    res0, res1;

    logic                  advance;
    logic                  in_accept;
    logic [FIFO_CNT_W-1:0] free_slots;
    logic                  fifo_not_empty;
    result_t               head;

    always_comb
    begin
        receiving_next = receiving_reg;
        complete_next  = complete_reg;
        escape_next    = escape_reg;
        count_next     = count_reg;
        expected_next  = expected_reg;
        rx_c           = s1_data_reg;
        exp_v          = expected_reg;
        cnt_inc        = 9'(count_reg + 1'b1);
        ovf            = 1'b0;
        fend           = 1'b0;
        n_results      = 2'd0;
        res0           = '0;
        res1           = '0;

        unique case (func_t'(s1_func_reg))
            FUNC_RX:
            begin
                if (!complete_reg)
                begin
                    if (!receiving_reg)
                    begin
                        if (s1_data_reg == start_flag_reg)
                        begin
                            receiving_next = 1'b1;
                            expected_next  = {1'b0, header_length_reg};
                            count_next     = '0;
                        end
                    end
                    else if (stuffing_reg && !escape_reg && s1_data_reg == ESC_BYTE)
                    begin
                        escape_next = 1'b1;
                    end
                    else
                    begin
                        if (stuffing_reg && escape_reg)
                        begin
                            escape_next = 1'b0;
                            rx_c        = s1_data_reg ^ ESC_MASK;
                        end
                        // length byte sets the frame length
                        if (count_reg == LEN_INDEX)
                        begin
                            exp_v = 9'({1'b0, rx_c} + LEN_ADD);
                        end
                        ovf           = (exp_v >= 9'(BUFFER_BYTES));
                        fend          = ovf || (cnt_inc >= exp_v);
                        expected_next = exp_v;
                        count_next    = cnt_inc;
                        if (fend)
                        begin
                            receiving_next = 1'b0;
                            complete_next  = 1'b1;
                        end
                        res0.kind      = 1'b0;
                        res0.data      = rx_c;
                        res0.index     = count_reg[7:0];
                        res0.frame_end = fend;
                        res0.overflow  = ovf;
                        res0.last      = 1'b1;
                        n_results      = 2'd1;
                    end
                end
            end
            FUNC_TX:
            begin
                res0.kind = 1'b1;
                res1.kind = 1'b1;
                if (stuffing_reg && (s1_data_reg == FLAG_BYTE || s1_data_reg == ESC_BYTE))
                begin
                    res0.data = ESC_BYTE;
                    res1.data = s1_data_reg ^ ESC_MASK;
                    res1.last = 1'b1;
                    n_results = 2'd2;
                end
                else
                begin
                    res0.data = s1_data_reg;
                    res0.last = 1'b1;
                    n_results = 2'd1;
                end
            end
            FUNC_RELEASE:
            begin
                complete_next = 1'b0;
            end
            FUNC_NOP:
            begin
            end
        endcase
    end

    // move on only when the queue has room for every result of this item
    assign advance       = s1_valid_reg && (FIFO_CNT_W'(n_results) <= free_slots);
    assign item_in.ready = !s1_valid_reg || advance;
    assign in_accept     = item_in.valid && item_in.ready;

    always_comb
    begin
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_func_reg <= item_in.func;
            s1_data_reg <= item_in.data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            receiving_reg     <= 1'b0;
            complete_reg      <= 1'b0;
            escape_reg        <= 1'b0;
            count_reg         <= '0;
            expected_reg      <= '0;
            start_flag_reg    <= START_FLAG_RESET;
            stuffing_reg      <= STUFFING_RESET;
            header_length_reg <= HEADER_LENGTH_RESET;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (advance)
            begin
                receiving_reg <= receiving_next;
                complete_reg  <= complete_next;
                escape_reg    <= escape_next;
                count_reg     <= count_next;
                expected_reg  <= expected_next;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_START_FLAG:    start_flag_reg    <= cfg_data[7:0];
                    CFG_STUFFING:      stuffing_reg      <= cfg_data[0];
                    CFG_HEADER_LENGTH: header_length_reg <= cfg_data[7:0];
                    default:           ;
                endcase
            end
        end
    end

    sfc_result_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (advance ? n_results : 2'd0),
        .push0      (res0),
        .push1      (res1),
        .pop        (item_out.ready),
        .head       (head),
        .not_empty  (fifo_not_empty),
        .free_slots (free_slots)
    );

    assign item_out.valid     = fifo_not_empty;
    assign item_out.out_kind  = head.kind;
    assign item_out.out_byte  = head.data;
    assign item_out.out_index = head.index;
    assign item_out.frame_end = head.frame_end;
    assign item_out.overflow  = head.overflow;
    assign item_out.last      = head.last;

endmodule
`default_nettype wire

// ----- hw/rtl/sfc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfc_checker
// port-level checks on the codec result stream
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfc_checker (
    input wire       clk,
    input wire       rst_n,
    input wire       out_valid,
    input wire       out_ready,
    input wire       out_kind,
    input wire [7:0] out_byte,
    input wire [7:0] out_index,
    input wire       out_frame_end,
    input wire       out_overflow,
    input wire       out_last
);
    import sfc_pkg::*;

    `SFC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
    `SFC_ASSERT_IMPLY(a_tx_fields, clk, rst_n, out_valid && out_kind, out_index == 8'd0 && !out_frame_end && !out_overflow, "transmit item carries receive fields")
    `SFC_ASSERT_IMPLY(a_ovf_ends, clk, rst_n, out_valid && out_overflow, out_frame_end, "overflow without frame end")
    `SFC_ASSERT_IMPLY(a_rx_last, clk, rst_n, out_valid && !out_kind, out_last, "received item not marked last")
    `SFC_ASSERT_IMPLY(a_tx_escape, clk, rst_n, out_valid && out_kind && !out_last, out_byte == ESC_BYTE, "first of a stuffed pair is not the escape byte")

endmodule

bind stuffed_serial_frame_codec_unit sfc_checker u_sfc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (item_out.valid),
    .out_ready     (item_out.ready),
    .out_kind      (item_out.out_kind),
    .out_byte      (item_out.out_byte),
    .out_index     (item_out.out_index),
    .out_frame_end (item_out.frame_end),
    .out_overflow  (item_out.overflow),
    .out_last      (item_out.last)
);
`default_nettype wire

// ----- verif/tb_stuffed_serial_frame_codec_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stuffed_serial_frame_codec_unit
// self-checking bench: frames, escapes and transmit bytes are driven through
// the command channel under random gaps and output stalls; every result is
// predicted from a model of the deframer and stuffer and checked in order
// ----------------------------------------------------------------------------
module tb_stuffed_serial_frame_codec_unit;
    import sfc_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 380;
    localparam int TIMEOUT_NS    = 10_000_000;

    class codec_result_board;
        localparam int REPORT_LIMIT = 10;

        logic [7:0] start_flag;
        logic       stuffing;
        logic [7:0] header_length;
        logic       receiving;
        logic       complete;
        logic       rx_esc;
        logic [8:0] rx_count;
        logic [8:0] frame_len;
        result_t    pending_results[$];
        int         mismatches;
        int         checked;
        int         items_seen;
        int         frames;
        int         overflows;
        int         stuffed_pairs;

        function new();
            start_flag    = START_FLAG_RESET;
            stuffing      = STUFFING_RESET;
            header_length = HEADER_LENGTH_RESET;
            receiving     = 1'b0;
            complete      = 1'b0;
            rx_esc        = 1'b0;
            rx_count      = '0;
            frame_len     = '0;
            mismatches    = 0;
            checked       = 0;
            items_seen    = 0;
            frames        = 0;
            overflows     = 0;
            stuffed_pairs = 0;
        endfunction

        function void write_register(cfg_reg_t idx, logic [7:0] value);
            case (idx)
                CFG_START_FLAG:    start_flag = value;
                CFG_STUFFING:      stuffing = value[0];
                CFG_HEADER_LENGTH: header_length = value;
                default: ;
            endcase
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        function void add_result(logic kind, logic [7:0] data, logic [7:0] index,
                                 logic fend, logic ovf, logic lst);
            result_t r;
            r.kind      = kind;
            r.data      = data;
            r.index     = index;
            r.frame_end = fend;
            r.overflow  = ovf;
            r.last      = lst;
            pending_results.push_back(r);
        endfunction

        function void deframe(logic [7:0] line_byte);
            logic [7:0] c;
            logic [8:0] idx;
            logic       ovf;
            logic       fend;
            c = line_byte;
            if (complete)
                return;
            if (!receiving)
            begin
                if (c == start_flag)
                begin
                    receiving = 1'b1;
                    frame_len = {1'b0, header_length};
                    rx_count  = '0;
                end
                return;
            end
            if (stuffing)
            begin
                if (rx_esc)
                begin
                    rx_esc = 1'b0;
                    c = c ^ ESC_MASK;
                end
                else if (c == ESC_BYTE)
                begin
                    rx_esc = 1'b1;
                    return;
                end
            end
            if (rx_count == LEN_INDEX)
                frame_len = {1'b0, c} + LEN_ADD;
            ovf = (int'(frame_len) >= BUFFER_BYTES);
            idx = rx_count;
            rx_count = rx_count + 9'd1;
            fend = ovf || (rx_count >= frame_len);
            if (fend)
            begin
                receiving = 1'b0;
                complete  = 1'b1;
                frames++;
                if (ovf)
                    overflows++;
            end
            add_result(1'b0, c, idx[7:0], fend, ovf, 1'b1);
        endfunction

        function void stuff(logic [7:0] b);
            if (stuffing && (b == FLAG_BYTE || b == ESC_BYTE))
            begin
                add_result(1'b1, ESC_BYTE, 8'd0, 1'b0, 1'b0, 1'b0);
                add_result(1'b1, b ^ ESC_MASK, 8'd0, 1'b0, 1'b0, 1'b1);
                stuffed_pairs++;
            end
            else
                add_result(1'b1, b, 8'd0, 1'b0, 1'b0, 1'b1);
        endfunction

        function void note_item(func_t f, logic [7:0] b);
            items_seen++;
            case (f)
                FUNC_RX:      deframe(b);
                FUNC_TX:      stuff(b);
                FUNC_RELEASE: complete = 1'b0;
                default: ;
            endcase
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("unexpected result:");
                    $display("  kind %0d byte %02h index %0d end %0d ovf %0d last %0d",
                             got.kind, got.data, got.index, got.frame_end, got.overflow,
                             got.last);
                end
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (got.kind !== want.kind || got.data !== want.data || got.index !== want.index ||
                got.frame_end !== want.frame_end || got.overflow !== want.overflow ||
                got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("result %0d mismatch", checked);
                    $display("  expected kind %0d byte %02h index %0d end %0d ovf %0d last %0d",
                             want.kind, want.data, want.index, want.frame_end,
                             want.overflow, want.last);
                    $display("  actual   kind %0d byte %02h index %0d end %0d ovf %0d last %0d",
                             got.kind, got.data, got.index, got.frame_end,
                             got.overflow, got.last);
                end
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    sfc_in_if  cmd_if ();
    sfc_out_if res_if ();

    codec_result_board sb;
    bit steady;
    bit hold_request;
    int holds_done;
    int settings_used;

    stuffed_serial_frame_codec_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item_in   (cmd_if),
        .item_out  (res_if)
    );

    always
    begin
        clk = 1'b0;
        #HALF_PERIOD;
        clk = 1'b1;
        #HALF_PERIOD;
    end

    function automatic int draw_wait();
        return steady ? 0 : $urandom_range(0, 4);
    endfunction

    function automatic logic [7:0] tx_pick();
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(0, 1) ? FLAG_BYTE : ESC_BYTE;
        return 8'($urandom_range(0, 255));
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(func_t f, logic [7:0] b);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_if.valid     <= 1'b1;
        cmd_if.func      <= f;
        cmd_if.data_byte <= b;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        sb.note_item(f, b);
        @(negedge clk);
    endtask

    // escape bytes cause no result, so allow the pipe to settle afterwards
    task automatic wait_idle();
        cmd_if.valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        sb.write_register(idx, value);
    endtask

    task automatic configure(logic [7:0] flag, logic stuff_on, logic [7:0] hdr);
        wait_idle();
        write_reg(CFG_START_FLAG, flag);
        write_reg(CFG_STUFFING, {7'd0, stuff_on});
        write_reg(CFG_HEADER_LENGTH, hdr);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // one frame byte on the line, escaped where needed and now and then anyway
    task automatic send_payload_byte(logic [7:0] v);
        if (sb.stuffing && (v == ESC_BYTE || v == FLAG_BYTE || $urandom_range(0, 9) == 0))
        begin
            send_item(FUNC_RX, ESC_BYTE);
            send_item(FUNC_RX, v ^ ESC_MASK);
        end
        else
            send_item(FUNC_RX, v);
        if ($urandom_range(0, 7) == 0)
            send_item(FUNC_TX, tx_pick());
    endtask

    task automatic send_frame();
        logic [7:0] len_val;
        int         n;
        case ($urandom_range(0, 19))
            14, 15, 16: len_val = 8'($urandom_range(250, 255));
            17, 18:     len_val = 8'($urandom_range(7, 40));
            19:         len_val = 8'($urandom_range(60, 120));
            default:    len_val = 8'($urandom_range(0, 6));
        endcase
        n = (len_val >= 8'd250) ? 3 : int'(len_val) + 6;
        send_item(FUNC_RX, sb.start_flag);
        for (int i = 0; i < n; i++)
            send_payload_byte(i == 2 ? len_val : 8'($urandom_range(0, 255)));
        // trailing byte lands on a completed frame
        if ($urandom_range(0, 4) == 0)
            send_item(FUNC_RX, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) != 0)
            send_item(FUNC_RELEASE, 8'($urandom_range(0, 255)));
    endtask

    task automatic run_phase(int quota);
        int stop_at;
        int r;
        stop_at = sb.items_seen + quota;
        while (sb.items_seen < stop_at)
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
                send_frame();
            else if (r < 80)
                repeat ($urandom_range(1, 4)) send_item(FUNC_TX, tx_pick());
            else if (r < 95)
                send_item(func_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            else
                send_item(FUNC_RELEASE, 8'($urandom_range(0, 255)));
        end
    endtask

    // result side: random stalls per item plus one long hold-off on request
    initial
    begin
        int      k;
        result_t got;
        res_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_request)
            begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
                holds_done++;
            end
            k = draw_wait();
            if (k > 0)
            begin
                res_if.ready <= 1'b0;
                repeat (k) @(negedge clk);
            end
            res_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_if.valid);
            got.kind      = res_if.out_kind;
            got.data      = res_if.out_byte;
            got.index     = res_if.out_index;
            got.frame_end = res_if.frame_end;
            got.overflow  = res_if.overflow;
            got.last      = res_if.last;
            sb.check_result(got);
            @(negedge clk);
        end
    end

    initial
    begin
        #TIMEOUT_NS;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = CFG_START_FLAG;
        cfg_data         = '0;
        cmd_if.valid     = 1'b0;
        cmd_if.func      = FUNC_NOP;
        cmd_if.data_byte = '0;
        steady           = 1'b0;
        hold_request     = 1'b0;
        holds_done       = 0;
        settings_used    = 1;
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // stray byte while idle, early release, no-op, plain and escaped transmit
        send_item(FUNC_RX, 8'h55);
        send_item(FUNC_RELEASE, 8'h00);
        send_item(FUNC_NOP, 8'hff);
        send_item(FUNC_TX, 8'h00);
        send_item(FUNC_TX, 8'hff);
        send_item(FUNC_TX, FLAG_BYTE);
        send_item(FUNC_TX, ESC_BYTE);
        // frame: flag inside as data, escaped bytes, length six
        send_item(FUNC_RX, FLAG_BYTE);
        send_item(FUNC_RX, FLAG_BYTE);
        send_item(FUNC_RX, ESC_BYTE);
        send_item(FUNC_RX, 8'h5e);
        send_item(FUNC_RX, 8'h00);
        send_item(FUNC_RX, 8'hff);
        send_item(FUNC_RX, 8'h01);
        send_item(FUNC_RX, ESC_BYTE);
        send_item(FUNC_RX, 8'h5d);
        send_item(FUNC_RX, 8'h12);
        send_item(FUNC_RELEASE, 8'h00);
        // length byte pushes the frame past the buffer
        send_item(FUNC_RX, FLAG_BYTE);
        send_item(FUNC_RX, 8'h00);
        send_item(FUNC_RX, 8'h00);
        send_item(FUNC_RX, 8'hfa);
        send_item(FUNC_RELEASE, 8'h00);
        // leave an escape pending across the switch to unstuffed mode
        send_item(FUNC_RX, FLAG_BYTE);
        send_item(FUNC_RX, ESC_BYTE);

        configure(8'h00, 1'b0, 8'd3);
        run_phase(PHASE_ITEMS);
        configure(8'hff, 1'b1, 8'd255);
        steady = 1'b1;
        run_phase(PHASE_ITEMS);
        steady = 1'b0;
        configure(ESC_BYTE, 1'b1, 8'd128);
        run_phase(PHASE_ITEMS);
        configure(START_FLAG_RESET, STUFFING_RESET, HEADER_LENGTH_RESET);
        run_phase(100);
        hold_request = 1'b1;
        run_phase(PHASE_ITEMS - 100);
        configure(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  8'($urandom_range(3, 255)));
        run_phase(PHASE_ITEMS);
        wait_idle();

        $display("run covered %0d frames (%0d cut at the buffer limit), %0d escaped tx bytes",
                 sb.frames, sb.overflows, sb.stuffed_pairs);
        $display("%0d items sent, %0d results checked, %0d register settings, %0d hold-offs",
                 sb.items_seen, sb.checked, settings_used, holds_done);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
